/* src/multi_pattern_string_matcher_defines.svh */
// Assertion macros for the multi-pattern string matcher.
`ifndef MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define MPSM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPSM_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MPSM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MPSM_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* src/mpsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types and constants for the multi-pattern string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int NODES_DEFAULT    = 1024;
    localparam int ALPHABET_DEFAULT = 26;
    localparam int SYM_W            = 5;
    localparam int NODE_W           = 10;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_BUILD  = 2'd2,
        OP_SCAN   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SYM_W-1:0]  symbol;
        logic              last;
    } in_beat_t;

    typedef struct packed {
        logic              hit;
        logic [NODE_W-1:0] node;
        logic              status;
    } out_beat_t;

endpackage

/* src/mpsm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_in_if / mpsm_out_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface mpsm_in_if import mpsm_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    modport source (output valid, opcode, symbol, last, input ready);
    modport sink   (input valid, opcode, symbol, last, output ready);
endinterface

interface mpsm_out_if import mpsm_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [NODE_W-1:0] node;
    logic              status;
    modport source (output valid, hit, node, status, input ready);
    modport sink   (input valid, hit, node, status, output ready);
endinterface

/* src/multi_pattern_string_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick automaton over a node table held in block memories.
// ----------------------------------------------------------------------------
// Scan, and insert into an existing node, pass through read, execute and output states.
// A node-allocating insert clears the new row entry by entry; clear does so for the root row.
// Build walks the nodes breadth first through a queue to set failure links.
// One item is in work at a time; a new input beat waits until the result beat is accepted.
// Reset is asynchronous active low; a root clearing pass with no result beat follows it.
`include "multi_pattern_string_matcher_defines.svh"

module multi_pattern_string_matcher
    import mpsm_pkg::*;
#(
    parameter int NODES    = NODES_DEFAULT,
    parameter int ALPHABET = ALPHABET_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    mpsm_in_if.sink    in_ch,
    mpsm_out_if.source out_ch
);

    localparam int NW = $clog2(NODES);
    localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int TD = NODES * ALPHABET;
    localparam int TW = $clog2(TD);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD    = 13'b0000000000010,
        S_EXEC  = 13'b0000000000100,
        S_ZERO  = 13'b0000000001000,
        S_OUT   = 13'b0000000010000,
        S_BPOP  = 13'b0000000100000,
        S_BFL   = 13'b0000001000000,
        S_BRD   = 13'b0000010000000,
        S_BCHK  = 13'b0000100000000,
        S_BFRD  = 13'b0001000000000,
        S_BFWR  = 13'b0010000000000,
        S_BEND  = 13'b0100000000000,
        S_BPROP = 13'b1000000000000
    } state_t;

    // Memories. Rows never allocated are never read.
    logic [NW-1:0] trans_mem [TD];
    logic [NW-1:0] fail_mem  [NODES];
    logic          mark_mem  [NODES];
    logic [NW-1:0] queue_mem [NODES];

    state_t            state_reg, state_next;
    logic [1:0]        op_reg;
    logic [SYM_W-1:0]  sym_reg;
    logic              last_reg;
    logic [NW-1:0]     used_reg, ins_reg, scan_reg;
    logic              drop_reg, built_reg;
    logic              init_reg;
    logic [AW-1:0]     zcnt_reg;
    logic [NW:0]       head_reg, tail_reg;
    logic [NW-1:0]     now_reg, nowf_reg, child_reg;
    logic [AW-1:0]     idx_reg;
    logic              ovalid_reg;
    out_beat_t         obeat_reg;

    logic [NW-1:0]     trd_reg, frd_reg, qrd_reg;
    logic              mrd_reg;

    // Memory port control.
    logic          t_we, f_we, m_we, q_we;
    logic [TW-1:0] t_addr;
    logic [NW-1:0] t_wd, f_addr, f_wd, m_addr, q_addr, q_wd;
    logic          m_wd;

    function automatic logic [TW-1:0] taddr(logic [NW-1:0] n, logic [AW-1:0] s);
        logic [TW-1:0] p;
        p = TW'(n) * TW'(ALPHABET) + TW'(s);
        return p;
    endfunction

    logic sym_ok;
    logic [AW-1:0] sym_i;
    assign sym_ok = (32'(sym_reg) < 32'(ALPHABET));
    assign sym_i  = AW'(sym_reg);

    logic in_acc, out_acc;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_ch.valid && out_ch.ready;
    assign out_ch.valid  = ovalid_reg;
    assign out_ch.hit    = obeat_reg.hit;
    assign out_ch.node   = obeat_reg.node;
    assign out_ch.status = obeat_reg.status;

    logic ins_ok;
    assign ins_ok = !built_reg && !drop_reg && sym_ok;

    // Sequencer and memory port decode.
    always_comb
    begin
        state_next = state_reg;
        t_we = 1'b0; f_we = 1'b0; m_we = 1'b0; q_we = 1'b0;
        t_addr = '0; t_wd = '0; f_addr = '0; f_wd = '0;
        m_addr = '0; m_wd = 1'b0; q_addr = '0; q_wd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // Issue the table read that a scan or an insert needs.
                t_addr = taddr((op_reg == OP_SCAN) ? scan_reg : ins_reg, sym_i);
                if (op_reg == OP_CLEAR)
                begin
                    f_we = 1'b1; m_we = 1'b1;
                    state_next = S_ZERO;
                end
                else if (op_reg == OP_BUILD)
                begin
                    q_we = 1'b1;
                    state_next = built_reg ? S_OUT : S_BPOP;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_SCAN)
                begin
                    m_addr = sym_ok ? trd_reg : '0;
                    state_next = S_OUT;
                end
                else if (ins_ok && trd_reg == '0 && 32'(used_reg) < NODES - 1)
                begin
                    t_we = 1'b1; t_addr = taddr(ins_reg, sym_i);
                    t_wd = used_reg + 1'b1;
                    f_we = 1'b1; f_addr = used_reg + 1'b1;
                    m_we = 1'b1; m_addr = used_reg + 1'b1; m_wd = last_reg;
                    state_next = S_ZERO;
                end
                else
                begin
                    if (ins_ok && trd_reg != '0 && last_reg)
                    begin
                        m_we = 1'b1; m_addr = trd_reg; m_wd = 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_ZERO:
            begin
                // Clear one entry of the fresh row per cycle.
                t_we = 1'b1; t_addr = taddr(child_reg, zcnt_reg);
                if (32'(zcnt_reg) == ALPHABET - 1)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            S_BPOP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    q_addr = head_reg[NW-1:0];
                    state_next = S_BFL;
                end
            end
            S_BFL:
            begin
                f_addr = qrd_reg;
                state_next = S_BRD;
            end
            S_BRD:
            begin
                t_addr = taddr(now_reg, idx_reg);
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (trd_reg != '0)
                begin
                    if (tail_reg < (NW+1)'(NODES))
                    begin
                        q_we = 1'b1; q_addr = tail_reg[NW-1:0]; q_wd = trd_reg;
                    end
                    t_addr = taddr(nowf_reg, idx_reg);
                    state_next = (now_reg != '0) ? S_BFRD : S_BEND;
                end
                else
                begin
                    t_addr = taddr(nowf_reg, idx_reg);
                    state_next = S_BFRD;
                end
            end
            S_BFRD:
            begin
                if (child_reg != '0)
                begin
                    f_we = 1'b1; f_addr = child_reg; f_wd = trd_reg;
                    state_next = S_BEND;
                end
                else
                begin
                    t_we = 1'b1; t_addr = taddr(now_reg, idx_reg); t_wd = trd_reg;
                    state_next = S_BFWR;
                end
            end
            S_BFWR:
            begin
                if (32'(idx_reg) == ALPHABET - 1)
                    state_next = S_BPOP;
                else
                    state_next = S_BRD;
            end
            S_BEND:
            begin
                // Read the link of child, then the end mark of the node it links to.
                f_addr = child_reg;
                state_next = S_BPROP;
            end
            S_BPROP:
            begin
                if (zcnt_reg == '0)
                begin
                    m_addr = frd_reg;
                end
                else
                begin
                    m_we = mrd_reg; m_addr = child_reg; m_wd = 1'b1;
                    state_next = S_BFWR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Block memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (t_we) trans_mem[t_addr] <= t_wd;
        trd_reg <= trans_mem[t_addr];
        if (f_we) fail_mem[f_addr] <= f_wd;
        frd_reg <= fail_mem[f_addr];
        if (m_we) mark_mem[m_addr] <= m_wd;
        mrd_reg <= mark_mem[m_addr];
        if (q_we) queue_mem[q_addr] <= q_wd;
        qrd_reg <= queue_mem[q_addr];
    end

    // Datapath and control registers. Reset starts a clear with no result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RD;
            init_reg   <= 1'b1;
            used_reg   <= '0;
            ins_reg    <= '0;
            scan_reg   <= '0;
            drop_reg   <= 1'b0;
            built_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            zcnt_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            idx_reg    <= '0;
            now_reg    <= '0;
            nowf_reg   <= '0;
            child_reg  <= '0;
            op_reg     <= OP_CLEAR;
            sym_reg    <= '0;
            last_reg   <= 1'b0;
            obeat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_acc)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg    <= in_ch.opcode;
                        sym_reg   <= in_ch.symbol;
                        last_reg  <= in_ch.last;
                        obeat_reg <= '0;
                        zcnt_reg  <= '0;
                        child_reg <= '0;
                    end
                end
                S_RD:
                begin
                    if (op_reg == OP_CLEAR)
                    begin
                        used_reg <= '0; ins_reg <= '0; scan_reg <= '0;
                        drop_reg <= 1'b0; built_reg <= 1'b0;
                    end
                    else if (op_reg == OP_BUILD && !built_reg)
                    begin
                        head_reg <= '0; tail_reg <= (NW+1)'(1);
                    end
                end
                S_EXEC:
                begin
                    if (op_reg == OP_SCAN)
                    begin
                        scan_reg <= sym_ok ? trd_reg : '0;
                        obeat_reg.node <= NODE_W'(sym_ok ? trd_reg : '0);
                    end
                    else
                    begin
                        if (!ins_ok || (trd_reg == '0 && 32'(used_reg) >= NODES - 1))
                        begin
                            obeat_reg.status <= 1'b1;
                            if (!last_reg)
                                drop_reg <= 1'b1;
                        end
                        else if (trd_reg == '0)
                        begin
                            used_reg  <= used_reg + 1'b1;
                            child_reg <= used_reg + 1'b1;
                            obeat_reg.node <= NODE_W'(used_reg + 1'b1);
                            if (!last_reg)
                                ins_reg <= used_reg + 1'b1;
                        end
                        else
                        begin
                            obeat_reg.node <= NODE_W'(trd_reg);
                            if (!last_reg)
                                ins_reg <= trd_reg;
                        end
                        // The final letter returns the keyword to the root.
                        if (last_reg)
                        begin
                            ins_reg  <= '0;
                            drop_reg <= 1'b0;
                        end
                    end
                end
                S_ZERO:
                begin
                    zcnt_reg <= zcnt_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (op_reg == OP_SCAN)
                        obeat_reg.hit <= mrd_reg;
                    if (op_reg == OP_BUILD)
                        built_reg <= 1'b1;
                    init_reg   <= 1'b0;
                    ovalid_reg <= !init_reg;
                end
                S_BPOP:
                begin
                    if (head_reg != tail_reg)
                        head_reg <= head_reg + 1'b1;
                    idx_reg <= '0;
                end
                S_BFL:
                begin
                    now_reg <= qrd_reg;
                end
                S_BRD:
                begin
                    // The link of the popped node is read once, before its first letter.
                    if (idx_reg == '0)
                        nowf_reg <= frd_reg;
                end
                S_BCHK:
                begin
                    child_reg <= trd_reg;
                    zcnt_reg  <= '0;
                    if (trd_reg != '0 && tail_reg < (NW+1)'(NODES))
                        tail_reg <= tail_reg + 1'b1;
                end
                S_BFWR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                S_BPROP:
                begin
                    zcnt_reg <= zcnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    `MPSM_ASSERT_NEVER(a_busy_ready, clk, rst_n, in_ch.ready && state_reg != S_IDLE, "ready while busy")
    `MPSM_ASSERT_NEVER(a_used_range, clk, rst_n, 32'(used_reg) > NODES - 1, "node count overflow")
    `MPSM_ASSERT_IMPL(a_out_one, clk, rst_n, state_reg == S_OUT && !init_reg |=> out_ch.valid, "result lost")
    `MPSM_ASSERT_NEVER(a_queue, clk, rst_n, head_reg > tail_reg, "queue underrun")

endmodule
